[rtl/rlbm_pkg.sv]
// Shared types, codes and constants of the ranked legal bit mutator.
`default_nettype none

package rlbm_pkg;

    localparam int MAX_CELLS_DEFAULT = 1024;
    localparam int CFG_W             = 11;
    localparam int CELLS_RESET       = 1024;
    localparam int OP_W              = 2;
    localparam int IDX_W             = 10;
    localparam int RAND_W            = 31;
    localparam int TOTAL_W           = 11;
    localparam int CELL_W            = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_MUTATE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        logic [RAND_W-1:0] rand_remove;
        logic [RAND_W-1:0] rand_add;
        logic              do_remove;
        logic              do_add;
        logic              legal_in;
        logic              present_in;
        logic [IDX_W-1:0]  cell_index;
    } item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] present_count;
        logic               remove_done;
        logic               add_done;
        logic [IDX_W-1:0]   removed_cell;
        logic [IDX_W-1:0]   added_cell;
        logic               read_legal;
        logic               read_present;
    } result_t;

    localparam int ITEM_W       = $bits(item_t);
    localparam int RES_W        = $bits(result_t);
    localparam int IN_TDATA_W   = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CELL_RD,
        S_CELL_UPD,
        S_COUNT,
        S_DIVA_LD,
        S_DIVA_RUN,
        S_DIVR_LD,
        S_DIVR_RUN,
        S_FIND_INIT,
        S_FIND,
        S_SET,
        S_CLR,
        S_OUT
    } ctl_state_t;

    typedef struct packed {
        logic load_item;
        logic rd_item;
        logic wr_item;
        logic scan_clear;
        logic scan_step;
        logic find_mode;
        logic div_load;
        logic div_sel_rem;
        logic store_add;
        logic store_rem;
        logic set_add;
        logic clr_rem;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic init_busy;
        logic scan_done;
        logic div_busy;
        logic out_free;
    } ctl_status_t;

endpackage

`default_nettype wire

[rtl/rlbm_ram.sv]
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module rlbm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/rlbm_ctrl.sv]
// Sequencer for cell access and the count, divide, find and update steps of a mutate.
`default_nettype none

module rlbm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire rlbm_pkg::op_t         item_op,
    output logic                       s_tready,
    input  wire rlbm_pkg::ctl_status_t status,
    output rlbm_pkg::ctl_cmd_t         cmd
);

    import rlbm_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (!status.init_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (item_op)
                        OP_WRITE, OP_READ: state_next = S_CELL_RD;
                        OP_MUTATE:         state_next = S_COUNT;
                        OP_NOP:            state_next = S_OUT;
                    endcase
                end
            end
            S_CELL_RD:
            begin
                state_next = (status.op == OP_WRITE) ? S_CELL_UPD : S_OUT;
            end
            S_CELL_UPD:  state_next = S_OUT;
            S_COUNT:
            begin
                if (status.scan_done)
                begin
                    state_next = S_DIVA_LD;
                end
            end
            S_DIVA_LD:   state_next = S_DIVA_RUN;
            S_DIVA_RUN:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_DIVR_LD;
                end
            end
            S_DIVR_LD:   state_next = S_DIVR_RUN;
            S_DIVR_RUN:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_FIND_INIT;
                end
            end
            S_FIND_INIT: state_next = S_FIND;
            S_FIND:
            begin
                if (status.scan_done)
                begin
                    state_next = S_SET;
                end
            end
            S_SET:       state_next = S_CLR;
            S_CLR:       state_next = S_OUT;
            S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_INIT:      s_tready = 1'b0;
            S_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            S_CELL_RD:   cmd.rd_item = 1'b1;
            S_CELL_UPD:  cmd.wr_item = 1'b1;
            S_COUNT:     cmd.scan_step = 1'b1;
            S_DIVA_LD:   cmd.div_load = 1'b1;
            S_DIVA_RUN:  cmd.store_add = !status.div_busy;
            S_DIVR_LD:
            begin
                cmd.div_load    = 1'b1;
                cmd.div_sel_rem = 1'b1;
            end
            S_DIVR_RUN:  cmd.store_rem = !status.div_busy;
            S_FIND_INIT: cmd.scan_clear = 1'b1;
            S_FIND:
            begin
                cmd.scan_step = 1'b1;
                cmd.find_mode = 1'b1;
            end
            S_SET:       cmd.set_add = 1'b1;
            S_CLR:       cmd.clr_rem = 1'b1;
            S_OUT:       cmd.out_load = status.out_free;
            default:     cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !status.out_free) |=> state_reg == S_OUT)
        else $error("result step left while output still occupied");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |=> status.div_busy)
        else $error("modulo unit did not start after load");
`endif

endmodule

`default_nettype wire

[rtl/rlbm_dpath.sv]
// Datapath: cell store, counters, shared modulo unit, rank search and result register.
`default_nettype none

module rlbm_dpath #(
    parameter int MAX_CELLS = rlbm_pkg::MAX_CELLS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rlbm_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire rlbm_pkg::item_t               item,
    input  wire rlbm_pkg::op_t                 item_op,
    input  wire rlbm_pkg::ctl_cmd_t            cmd,
    output rlbm_pkg::ctl_status_t              status,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output rlbm_pkg::result_t                  result
);

    import rlbm_pkg::*;

    localparam int AW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int LW  = $clog2(MAX_CELLS + 1);
    localparam int IW  = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int CW  = (LW > CFG_W) ? LW : CFG_W;
    localparam int DCW = $clog2(RAND_W + 1);

    // item fields
    op_t               op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              pin_reg;
    logic              lin_reg;
    logic              do_add_reg;
    logic              do_rem_reg;
    logic [RAND_W-1:0] rand_add_reg;
    logic [RAND_W-1:0] rand_rem_reg;

    logic [CFG_W-1:0]   cfg_reg;
    logic [LW-1:0]      limit_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;

    logic          init_reg;
    logic [AW-1:0] init_addr_reg;

    logic [LW-1:0] scan_idx_reg;
    logic [LW-1:0] scan_idx_next;
    logic          pend_reg;
    logic [AW-1:0] pend_addr_reg;
    logic [LW-1:0] cnt_a_reg;
    logic [LW-1:0] cnt_a_next;
    logic [LW-1:0] cnt_p_reg;
    logic [LW-1:0] cnt_p_next;
    logic [LW-1:0] seen_a_reg;
    logic [LW-1:0] seen_a_next;
    logic [LW-1:0] seen_p_reg;
    logic [LW-1:0] seen_p_next;
    logic [AW-1:0] add_at_reg;
    logic [AW-1:0] add_at_next;
    logic [AW-1:0] rem_at_reg;
    logic [AW-1:0] rem_at_next;

    logic [RAND_W-1:0] quo_reg;
    logic [LW-1:0]     div_d_reg;
    logic [LW-1:0]     rem_reg;
    logic [DCW-1:0]    div_cnt_reg;
    logic              div_run_reg;
    logic [LW:0]       div_trial;
    logic [LW:0]       div_diff;
    logic [LW-1:0]     rem_next;

    logic [LW-1:0] rank_add_reg;
    logic [LW-1:0] rank_rem_reg;
    logic          add_go_reg;
    logic          rem_go_reg;

    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;

    logic [IW-1:0]     idx_wide;
    logic              in_range;
    logic [AW-1:0]     item_addr;
    logic [CW-1:0]     cfg_ext;
    logic [LW-1:0]     limit_next;
    logic              scan_issue;
    logic              hit;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    assign idx_wide  = IW'(idx_reg);
    assign in_range  = idx_wide < IW'(MAX_CELLS);
    assign item_addr = idx_wide[AW-1:0];
    assign cfg_ext   = CW'(cfg_reg);
    assign limit_next = (cfg_ext > CW'(MAX_CELLS)) ? LW'(MAX_CELLS) : LW'(cfg_reg);

    assign scan_issue = cmd.scan_step && (scan_idx_reg < limit_reg);
    // bit 1 legal, bit 0 present
    assign hit        = pend_reg && ram_rd_data[1];

    assign ram_rd_en   = (cmd.rd_item && in_range) || scan_issue;
    assign ram_rd_addr = scan_issue ? scan_idx_reg[AW-1:0] : item_addr;

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = item_addr;
        ram_wr_data = {lin_reg, pin_reg};
        priority if (init_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = init_addr_reg;
            ram_wr_data = '0;
        end
        else if (cmd.wr_item)
        begin
            ram_wr_en = in_range;
        end
        else if (cmd.set_add)
        begin
            ram_wr_en   = add_go_reg;
            ram_wr_addr = add_at_reg;
            ram_wr_data = 2'b11;
        end
        else if (cmd.clr_rem)
        begin
            ram_wr_en   = rem_go_reg;
            ram_wr_addr = rem_at_reg;
            ram_wr_data = 2'b10;
        end
    end

    rlbm_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_CELLS),
        .AW    (AW)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        total_next = total_reg;
        priority if (cmd.wr_item && in_range)
        begin
            if (ram_rd_data[0])
            begin
                total_next = total_next - TOTAL_W'(1);
            end
            if (pin_reg)
            begin
                total_next = total_next + TOTAL_W'(1);
            end
        end
        else if (cmd.set_add && add_go_reg)
        begin
            total_next = total_reg + TOTAL_W'(1);
        end
        else if (cmd.clr_rem && rem_go_reg)
        begin
            total_next = total_reg - TOTAL_W'(1);
        end
    end

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_p_next    = cnt_p_reg;
        seen_a_next   = seen_a_reg;
        seen_p_next   = seen_p_reg;
        add_at_next   = add_at_reg;
        rem_at_next   = rem_at_reg;
        if (cmd.load_item || cmd.scan_clear)
        begin
            scan_idx_next = '0;
            seen_a_next   = '0;
            seen_p_next   = '0;
        end
        else if (scan_issue)
        begin
            scan_idx_next = scan_idx_reg + LW'(1);
        end
        if (cmd.load_item)
        begin
            cnt_a_next = '0;
            cnt_p_next = '0;
        end
        else if (hit && !cmd.find_mode)
        begin
            if (ram_rd_data[0])
            begin
                cnt_p_next = cnt_p_reg + LW'(1);
            end
            else
            begin
                cnt_a_next = cnt_a_reg + LW'(1);
            end
        end
        if (hit && cmd.find_mode)
        begin
            if (ram_rd_data[0])
            begin
                if (seen_p_reg == rank_rem_reg)
                begin
                    rem_at_next = pend_addr_reg;
                end
                seen_p_next = seen_p_reg + LW'(1);
            end
            else
            begin
                if (seen_a_reg == rank_add_reg)
                begin
                    add_at_next = pend_addr_reg;
                end
                seen_a_next = seen_a_reg + LW'(1);
            end
        end
    end

    // one restoring step per cycle
    assign div_trial = {rem_reg, quo_reg[RAND_W-1]};
    assign div_diff  = div_trial - {1'b0, div_d_reg};
    assign rem_next  = (div_trial >= {1'b0, div_d_reg}) ? div_diff[LW-1:0] : div_trial[LW-1:0];

    always_comb
    begin
        out_next               = '0;
        out_next.present_count = total_reg;
        unique case (op_reg)
            OP_READ:
            begin
                out_next.read_present = in_range && ram_rd_data[0];
                out_next.read_legal   = in_range && ram_rd_data[1];
            end
            OP_MUTATE:
            begin
                out_next.add_done     = add_go_reg;
                out_next.remove_done  = rem_go_reg;
                out_next.added_cell   = add_go_reg ? IDX_W'(add_at_reg) : '0;
                out_next.removed_cell = rem_go_reg ? IDX_W'(rem_at_reg) : '0;
            end
            OP_WRITE, OP_NOP:
            begin
                out_next.read_present = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_W'(CELLS_RESET);
            total_reg     <= '0;
            init_reg      <= 1'b1;
            init_addr_reg <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            cnt_a_reg     <= '0;
            cnt_p_reg     <= '0;
            seen_a_reg    <= '0;
            seen_p_reg    <= '0;
            div_run_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            add_go_reg    <= 1'b0;
            rem_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (init_reg)
            begin
                init_addr_reg <= init_addr_reg + AW'(1);
                if (init_addr_reg == AW'(MAX_CELLS - 1))
                begin
                    init_reg <= 1'b0;
                end
            end
            total_reg    <= total_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= scan_issue;
            cnt_a_reg    <= cnt_a_next;
            cnt_p_reg    <= cnt_p_next;
            seen_a_reg   <= seen_a_next;
            seen_p_reg   <= seen_p_next;
            if (cmd.div_load)
            begin
                div_run_reg <= 1'b1;
                div_cnt_reg <= DCW'(RAND_W);
            end
            else if (div_run_reg)
            begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
                div_run_reg <= (div_cnt_reg != DCW'(1));
            end
            if (cmd.load_item)
            begin
                add_go_reg <= 1'b0;
                rem_go_reg <= 1'b0;
            end
            else
            begin
                if (cmd.store_add)
                begin
                    add_go_reg <= do_add_reg && (cnt_a_reg != '0);
                end
                if (cmd.store_rem)
                begin
                    rem_go_reg <= do_rem_reg && (cnt_p_reg != '0);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg       <= item_op;
            idx_reg      <= item.cell_index;
            pin_reg      <= item.present_in;
            lin_reg      <= item.legal_in;
            do_add_reg   <= item.do_add;
            do_rem_reg   <= item.do_remove;
            rand_add_reg <= item.rand_add;
            rand_rem_reg <= item.rand_remove;
            limit_reg    <= limit_next;
        end
        pend_addr_reg <= scan_idx_reg[AW-1:0];
        add_at_reg    <= add_at_next;
        rem_at_reg    <= rem_at_next;
        if (cmd.div_load)
        begin
            quo_reg   <= cmd.div_sel_rem ? rand_rem_reg : rand_add_reg;
            div_d_reg <= cmd.div_sel_rem ? cnt_p_reg : cnt_a_reg;
            rem_reg   <= '0;
        end
        else if (div_run_reg)
        begin
            quo_reg <= {quo_reg[RAND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.store_add)
        begin
            rank_add_reg <= rem_reg;
        end
        if (cmd.store_rem)
        begin
            rank_rem_reg <= rem_reg;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign status.op        = op_reg;
    assign status.init_busy = init_reg;
    assign status.scan_done = (scan_idx_reg == limit_reg) && !pend_reg;
    assign status.div_busy  = div_run_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

`ifndef ASSERT_OFF
    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store_add && cnt_a_reg != '0) |-> rem_reg < cnt_a_reg)
        else $error("add rank not below legal absent count");

    a_pass_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_add |-> (seen_a_reg == cnt_a_reg && seen_p_reg == cnt_p_reg))
        else $error("search pass saw other counts than count pass");

    a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clr_rem && add_go_reg && rem_go_reg) |-> add_at_reg != rem_at_reg)
        else $error("set and clear hit the same cell");
`endif

endmodule

`default_nettype wire

[rtl/ranked_legal_bit_mutator_unit.sv]
// Top level of the ranked legal bit mutator: stream ports, sequencer and datapath.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata item fields, s_tuser op
//  m_        out  m_tvalid/m_tready  m_tdata result fields
//  cfg_      in   cfg_we             cfg_wdata cells_in_use
//
//  A write item reads and then updates its cell, a read item only reads it, and a no-op item
//  goes straight to the result step. A mutate makes two scans of the
//  cell RAM at one read a cycle and two 31-step modulo passes through one shared unit.
//  One item is in work at a time; a new item is taken while the last result waits.
//  Reset clears the cell count register to 1024 and the present total to zero, then a
//  clearing pass over all MAX_CELLS addresses zeroes the cell RAM while s_tready is held low.
`default_nettype none

module ranked_legal_bit_mutator_unit #(
    parameter int MAX_CELLS = rlbm_pkg::MAX_CELLS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // cell_index, present_in, legal_in, do_add, do_remove, rand_add, rand_remove
    input  wire logic [rlbm_pkg::IN_TDATA_W-1:0]   s_tdata,
    // op
    input  wire logic [rlbm_pkg::OP_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // read_present, read_legal, added_cell, removed_cell, add_done, remove_done,
    // present_count
    output logic [rlbm_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [rlbm_pkg::CFG_W-1:0]        cfg_wdata
);

    import rlbm_pkg::*;

    item_t       item;
    op_t         item_op;
    result_t     result;
    ctl_cmd_t    cmd;
    ctl_status_t status;

    assign item    = item_t'(s_tdata[ITEM_W-1:0]);
    assign item_op = op_t'(s_tuser);
    assign m_tdata = OUT_TDATA_W'(result);

    rlbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .item_op  (item_op),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rlbm_dpath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .item_op   (item_op),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .result    (result)
    );

endmodule

`default_nettype wire
